FILE: rtl/ecc_pkg.sv
// Package with constants and calendar tables for the epoch calendar converter.
package ecc_pkg;

  // Seconds from the Unix epoch to 2000-01-01 00:00:00.
  localparam logic [31:0] UNIX_2000 = 32'd946684800;

  // Default number of years in the calendar window.
  localparam int YEAR_SPAN_DEF = 100;

  // Widths of the packed stream payloads.
  localparam int S_DATA_W = 72;
  localparam int M_DATA_W = 72;

  // Divisors, pre-shifted to the top quotient bit of each division.
  localparam logic [31:0] DVS_DAY  = 32'(64'd86400 << 15);
  localparam logic [31:0] DVS_HOUR = 32'(64'd3600 << 4);
  localparam logic [31:0] DVS_MIN  = 32'(64'd60 << 5);
  localparam logic [31:0] DVS_BLK  = 32'(64'd1461 << 5);
  localparam logic [31:0] DVS_WDAY = 32'(64'd7 << 8);

  // Length of month m (1..12) in a common year.
  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] len;
    case (m)
      4'd2:                            len = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:         len = 5'd30;
      default:                         len = 5'd31;
    endcase
    return len;
  endfunction

  // Days in the months before month m, capped at a whole year.
  function automatic logic [8:0] cum_days(input logic [3:0] m);
    logic [8:0] d;
    case (m)
      4'd0, 4'd1: d = 9'd0;
      4'd2:       d = 9'd31;
      4'd3:       d = 9'd59;
      4'd4:       d = 9'd90;
      4'd5:       d = 9'd120;
      4'd6:       d = 9'd151;
      4'd7:       d = 9'd181;
      4'd8:       d = 9'd212;
      4'd9:       d = 9'd243;
      4'd10:      d = 9'd273;
      4'd11:      d = 9'd304;
      4'd12:      d = 9'd334;
      default:    d = 9'd365;
    endcase
    return d;
  endfunction

  // Month offsets of the day-of-week rule, for month m (1..12).
  function automatic logic [2:0] sak_tab(input logic [3:0] m);
    logic [2:0] v;
    case (m)
      4'd2, 4'd6:   v = 3'd3;
      4'd3, 4'd11:  v = 3'd2;
      4'd4:         v = 3'd5;
      4'd7:         v = 3'd5;
      4'd8:         v = 3'd1;
      4'd9, 4'd12:  v = 3'd4;
      4'd10:        v = 3'd6;
      default:      v = 3'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/epoch_calendar_converter.sv
// Top level of the epoch calendar converter: sequencer around one compare-subtract unit.
//
// Converts between a 32-bit seconds count and a date and time in the window
// that starts at 2000-01-01. One beat on the slave stream is one request:
// s_axis_tuser selects the operation (0 = seconds to calendar, 1 = calendar
// to seconds) and s_axis_tdata carries the count and the date fields. Every
// request gives exactly one beat on the master stream; m_axis_tuser is the
// range flag. The unix_epoch register is written through cfg_we_i and
// cfg_wdata_i, and the user must write it only while the block is idle.
// The block itself does not enforce this. Seconds to calendar uses one 33-bit
// compare and subtract unit for five restoring divisions (16, 5, 6, 6 and 9
// quotient bits), one to four year steps, one to twelve month steps and a
// hand-off step. A date past the window skips the month walk and the weekday
// division. Calendar to seconds runs three multiply-add steps, the offset and
// the hand-off. One request is in work at a time; the next one can be taken
// as soon as a result is offered, since s_axis_tready is high while the
// sequencer is idle, also when a finished result still waits in the output
// register. When the receiver stalls, the next result waits at the end of
// its work.
// Reset clears the sequencer and the output valid, and sets unix_epoch to 1.
module epoch_calendar_converter
  import ecc_pkg::*;
#(
  parameter int YEAR_SPAN = YEAR_SPAN_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration: unix_epoch register.
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  // Request stream.
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // tdata from bit 0: seconds_in[31:0], year_offset[6:0], month[3:0], day[4:0],
  // hour[4:0], minute[5:0], second[5:0], zero fill.
  input  logic [S_DATA_W-1:0] s_axis_tdata,
  // tuser: operation.
  input  logic                s_axis_tuser,
  // Result stream.
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // tdata from bit 0: seconds_out[31:0], year_offset_out[6:0], month_out[3:0],
  // day_out[4:0], hour_out[4:0], minute_out[5:0], second_out[5:0],
  // weekday[2:0], zero fill.
  output logic [M_DATA_W-1:0] m_axis_tdata,
  // tuser: range_error.
  output logic                m_axis_tuser
);

  localparam logic [7:0] SpanLim = 8'(YEAR_SPAN);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_YEAR = 3'd2;
  localparam logic [2:0] ST_MON  = 3'd3;
  localparam logic [2:0] ST_MAC  = 3'd4;
  localparam logic [2:0] ST_OFS  = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  // Division being run by the shared unit.
  localparam logic [2:0] DIV_DAY  = 3'd0;
  localparam logic [2:0] DIV_HOUR = 3'd1;
  localparam logic [2:0] DIV_MIN  = 3'd2;
  localparam logic [2:0] DIV_BLK  = 3'd3;
  localparam logic [2:0] DIV_WDAY = 3'd4;

  logic [2:0]  state_q, state_d;
  logic [2:0]  div_sel_q, div_sel_d;
  logic [3:0]  cnt_q, cnt_d;
  logic        op_q, op_d;
  logic        unix_q;
  logic [31:0] rem_q, rem_d;
  logic [31:0] dvs_q, dvs_d;
  logic [15:0] quo_q, quo_d;
  logic [15:0] days_q, days_d;
  logic [5:0]  blk_q, blk_d;
  logic [1:0]  yk_q, yk_d;
  logic [6:0]  yoff_q, yoff_d;
  logic [3:0]  mon_q, mon_d;
  logic [4:0]  day_q, day_d;
  logic [4:0]  hour_q, hour_d;
  logic [5:0]  min_q, min_d;
  logic [5:0]  sec_q, sec_d;
  logic [2:0]  wday_q, wday_d;
  logic        err_q, err_d;
  logic        out_valid_q, out_valid_d;
  logic [M_DATA_W-1:0] out_data_q, out_data_d;
  logic        out_err_q, out_err_d;

  // Request fields.
  logic [31:0] in_secs;
  logic [6:0]  in_year;
  logic [3:0]  in_mon;
  logic [4:0]  in_day;
  logic [4:0]  in_hour;
  logic [5:0]  in_min;
  logic [5:0]  in_sec;

  assign in_secs = s_axis_tdata[31:0];
  assign in_year = s_axis_tdata[38:32];
  assign in_mon  = s_axis_tdata[42:39];
  assign in_day  = s_axis_tdata[47:43];
  assign in_hour = s_axis_tdata[52:48];
  assign in_min  = s_axis_tdata[58:53];
  assign in_sec  = s_axis_tdata[64:59];

  logic accept;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Shared compare-subtract unit: operand chosen by the sequencer state.
  logic [8:0]  ylen;
  logic [4:0]  mlen;
  logic [31:0] opnd;
  logic [32:0] diff;
  logic        ge;
  logic [15:0] q_next;

  assign ylen = (yk_q == 2'd0) ? 9'd366 : 9'd365;
  assign mlen = month_len(mon_q) + 5'((yk_q == 2'd0) && (mon_q == 4'd2));

  always_comb begin
    case (state_q)
      ST_YEAR: opnd = 32'(ylen);
      ST_MON:  opnd = 32'(mlen);
      default: opnd = dvs_q;
    endcase
  end

  assign diff   = {1'b0, rem_q} - {1'b0, opnd};
  assign ge     = !diff[32];
  assign q_next = {quo_q[14:0], ge};

  // Unix offset removal, clamped at the start of the window.
  logic [31:0] t_adj;
  always_comb begin
    if (!unix_q) begin
      t_adj = in_secs;
    end else if (in_secs < UNIX_2000) begin
      t_adj = '0;
    end else begin
      t_adj = in_secs - UNIX_2000;
    end
  end

  // Day count for a calendar request; wraps like every other sum here.
  logic [31:0] y32;
  logic [31:0] days_in;
  logic        leap_in;
  assign y32     = 32'(in_year);
  assign leap_in = (in_mon > 4'd2) && (in_year[1:0] == 2'b00);
  assign days_in = 32'(in_day) + 32'(cum_days(in_mon)) + 32'(leap_in) + y32 * 32'd365
                 + ((y32 + 32'd3) >> 2) - 32'd1;

  // Year offset and the day-of-week sum once the month is known.
  logic [7:0]  yoff_full;
  logic [4:0]  day_fin;
  logic [11:0] y_cal;
  logic [11:0] wsum;
  assign yoff_full = {blk_q, yk_q};
  assign day_fin   = rem_q[4:0] + 5'd1;
  assign y_cal     = 12'd2000 + 12'(yoff_q) - 12'(mon_q < 4'd3);
  assign wsum      = y_cal + (y_cal >> 2) - 12'd15 + 12'(sak_tab(mon_q)) + 12'(day_fin);

  // Multiply-add step for the calendar to seconds path.
  logic [5:0]  mac_k;
  logic [5:0]  mac_x;
  always_comb begin
    case (cnt_q[1:0])
      2'd0:    begin mac_k = 6'd24; mac_x = 6'(hour_q); end
      2'd1:    begin mac_k = 6'd60; mac_x = min_q; end
      default: begin mac_k = 6'd60; mac_x = sec_q; end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    div_sel_d   = div_sel_q;
    cnt_d       = cnt_q;
    op_d        = op_q;
    rem_d       = rem_q;
    dvs_d       = dvs_q;
    quo_d       = quo_q;
    days_d      = days_q;
    blk_d       = blk_q;
    yk_d        = yk_q;
    yoff_d      = yoff_q;
    mon_d       = mon_q;
    day_d       = day_q;
    hour_d      = hour_q;
    min_d       = min_q;
    sec_d       = sec_q;
    wday_d      = wday_q;
    err_d       = err_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_err_d   = out_err_q;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          op_d  = s_axis_tuser;
          err_d = 1'b0;
          if (s_axis_tuser) begin
            rem_d   = days_in;
            hour_d  = in_hour;
            min_d   = in_min;
            sec_d   = in_sec;
            cnt_d   = '0;
            state_d = ST_MAC;
          end else begin
            rem_d     = t_adj;
            dvs_d     = DVS_DAY;
            quo_d     = '0;
            cnt_d     = 4'd15;
            div_sel_d = DIV_DAY;
            state_d   = ST_DIV;
          end
        end
      end

      // One restoring division step per cycle.
      ST_DIV: begin
        if (ge) begin
          rem_d = diff[31:0];
        end
        quo_d = q_next;
        dvs_d = dvs_q >> 1;
        cnt_d = cnt_q - 4'd1;
        if (cnt_q == 4'd0) begin
          quo_d = '0;
          case (div_sel_q)
            DIV_DAY: begin
              days_d    = q_next;
              dvs_d     = DVS_HOUR;
              cnt_d     = 4'd4;
              div_sel_d = DIV_HOUR;
            end
            DIV_HOUR: begin
              hour_d    = q_next[4:0];
              dvs_d     = DVS_MIN;
              cnt_d     = 4'd5;
              div_sel_d = DIV_MIN;
            end
            DIV_MIN: begin
              min_d     = q_next[5:0];
              sec_d     = ge ? diff[5:0] : rem_q[5:0];
              rem_d     = 32'(days_q);
              dvs_d     = DVS_BLK;
              cnt_d     = 4'd5;
              div_sel_d = DIV_BLK;
            end
            DIV_BLK: begin
              blk_d   = q_next[5:0];
              yk_d    = '0;
              state_d = ST_YEAR;
            end
            default: begin
              wday_d  = (ge ? diff[2:0] : rem_q[2:0]) + 3'd1;
              state_d = ST_DONE;
            end
          endcase
        end
      end

      // Years inside a four-year block, the first one a leap year.
      ST_YEAR: begin
        if (ge) begin
          rem_d = diff[31:0];
          yk_d  = yk_q + 2'd1;
        end else if (yoff_full >= SpanLim) begin
          err_d   = 1'b1;
          yoff_d  = '0;
          mon_d   = 4'd1;
          day_d   = 5'd1;
          hour_d  = '0;
          min_d   = '0;
          sec_d   = '0;
          wday_d  = 3'd7;
          state_d = ST_DONE;
        end else begin
          yoff_d  = yoff_full[6:0];
          mon_d   = 4'd1;
          state_d = ST_MON;
        end
      end

      // Month walk, then start the day-of-week reduction.
      ST_MON: begin
        if ((mon_q < 4'd12) && ge) begin
          rem_d = diff[31:0];
          mon_d = mon_q + 4'd1;
        end else begin
          day_d     = day_fin;
          rem_d     = 32'(wsum);
          dvs_d     = DVS_WDAY;
          quo_d     = '0;
          cnt_d     = 4'd8;
          div_sel_d = DIV_WDAY;
          state_d   = ST_DIV;
        end
      end

      // Hours, minutes and seconds folded in one step at a time.
      ST_MAC: begin
        rem_d = rem_q * 32'(mac_k) + 32'(mac_x);
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd2) begin
          state_d = ST_OFS;
        end
      end

      ST_OFS: begin
        if (unix_q) begin
          rem_d = rem_q + UNIX_2000;
        end
        state_d = ST_DONE;
      end

      // Hand the result to the output register once it is free.
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          if (op_q) begin
            out_data_d = M_DATA_W'(rem_q);
            out_err_d  = 1'b0;
          end else begin
            out_data_d = M_DATA_W'({wday_q, sec_q, min_q, hour_q, day_q, mon_q, yoff_q,
                                    32'd0});
            out_err_d  = err_q;
          end
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      unix_q      <= 1'b1;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unix_q <= cfg_wdata_i;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    div_sel_q  <= div_sel_d;
    cnt_q      <= cnt_d;
    op_q       <= op_d;
    rem_q      <= rem_d;
    dvs_q      <= dvs_d;
    quo_q      <= quo_d;
    days_q     <= days_d;
    blk_q      <= blk_d;
    yk_q       <= yk_d;
    yoff_q     <= yoff_d;
    mon_q      <= mon_d;
    day_q      <= day_d;
    hour_q     <= hour_d;
    min_q      <= min_d;
    sec_q      <= sec_d;
    wday_q     <= wday_d;
    err_q      <= err_d;
    out_data_q <= out_data_d;
    out_err_q  <= out_err_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_err_q;

endmodule
